// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. Empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLKED(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_CLKED(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/brm_pkg.sv =====
`default_nettype none
package brm_pkg;

	localparam int unsigned VALUE_W = 12;
	localparam int unsigned SYM_W   = 8;
	localparam int unsigned STEP_W  = 5;

	localparam logic [VALUE_W-1:0] MAX_VALID = 12'd3999;

	localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;
	localparam logic [SYM_W-1:0] SYM_I    = 8'h49;
	localparam logic [SYM_W-1:0] SYM_V    = 8'h56;
	localparam logic [SYM_W-1:0] SYM_X    = 8'h58;
	localparam logic [SYM_W-1:0] SYM_L    = 8'h4C;
	localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
	localparam logic [SYM_W-1:0] SYM_D    = 8'h44;
	localparam logic [SYM_W-1:0] SYM_M    = 8'h4D;

	typedef enum logic [1:0] {
		OP_CHECK,
		OP_TERM,
		OP_SECOND
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [VALUE_W-1:0] weight;
		logic [SYM_W-1:0]   sym;
		logic               pair;
		logic [STEP_W-1:0]  fail_step;
	} ucode_t;

	typedef struct packed {
		logic               load;
		logic               sub;
		logic               emit;
		logic               last;
		logic               err;
		logic [SYM_W-1:0]   sym;
		logic [VALUE_W-1:0] weight;
	} dp_ctrl_t;

	typedef struct packed {
		logic ge;
		logic zero_after;
		logic rest_zero;
		logic bad;
		logic out_free;
	} dp_stat_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
	} in_payload_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
		logic             range_error;
	} out_payload_t;

endpackage
`default_nettype wire

// ===== src/brm_stream_if.sv =====
`default_nettype none
interface brm_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/brm_ucode_rom.sv =====
`default_nettype none
// Microprogram: a range check, then one step per greedy term and one more
// step for the second symbol of each subtractive pair.
module brm_ucode_rom (
	input  wire logic [brm_pkg::STEP_W-1:0] step,
	output brm_pkg::ucode_t                 uc
);
	always_comb begin
		unique case (step)
			5'd0:  uc = '{brm_pkg::OP_CHECK,  12'd0,    brm_pkg::SYM_NONE, 1'b0, 5'd1};
			5'd1:  uc = '{brm_pkg::OP_TERM,   12'd1000, brm_pkg::SYM_M,    1'b0, 5'd2};
			5'd2:  uc = '{brm_pkg::OP_TERM,   12'd900,  brm_pkg::SYM_C,    1'b1, 5'd4};
			5'd3:  uc = '{brm_pkg::OP_SECOND, 12'd0,    brm_pkg::SYM_M,    1'b0, 5'd4};
			5'd4:  uc = '{brm_pkg::OP_TERM,   12'd500,  brm_pkg::SYM_D,    1'b0, 5'd5};
			5'd5:  uc = '{brm_pkg::OP_TERM,   12'd400,  brm_pkg::SYM_C,    1'b1, 5'd7};
			5'd6:  uc = '{brm_pkg::OP_SECOND, 12'd0,    brm_pkg::SYM_D,    1'b0, 5'd7};
			5'd7:  uc = '{brm_pkg::OP_TERM,   12'd100,  brm_pkg::SYM_C,    1'b0, 5'd8};
			5'd8:  uc = '{brm_pkg::OP_TERM,   12'd90,   brm_pkg::SYM_X,    1'b1, 5'd10};
			5'd9:  uc = '{brm_pkg::OP_SECOND, 12'd0,    brm_pkg::SYM_C,    1'b0, 5'd10};
			5'd10: uc = '{brm_pkg::OP_TERM,   12'd50,   brm_pkg::SYM_L,    1'b0, 5'd11};
			5'd11: uc = '{brm_pkg::OP_TERM,   12'd40,   brm_pkg::SYM_X,    1'b1, 5'd13};
			5'd12: uc = '{brm_pkg::OP_SECOND, 12'd0,    brm_pkg::SYM_L,    1'b0, 5'd13};
			5'd13: uc = '{brm_pkg::OP_TERM,   12'd10,   brm_pkg::SYM_X,    1'b0, 5'd14};
			5'd14: uc = '{brm_pkg::OP_TERM,   12'd9,    brm_pkg::SYM_I,    1'b1, 5'd16};
			5'd15: uc = '{brm_pkg::OP_SECOND, 12'd0,    brm_pkg::SYM_X,    1'b0, 5'd16};
			5'd16: uc = '{brm_pkg::OP_TERM,   12'd5,    brm_pkg::SYM_V,    1'b0, 5'd17};
			5'd17: uc = '{brm_pkg::OP_TERM,   12'd4,    brm_pkg::SYM_I,    1'b1, 5'd19};
			5'd18: uc = '{brm_pkg::OP_SECOND, 12'd0,    brm_pkg::SYM_V,    1'b0, 5'd19};
			5'd19: uc = '{brm_pkg::OP_TERM,   12'd1,    brm_pkg::SYM_I,    1'b0, 5'd0};
			default: uc = '{brm_pkg::OP_CHECK, 12'd0,   brm_pkg::SYM_NONE, 1'b0, 5'd0};
		endcase
	end
endmodule
`default_nettype wire

// ===== src/brm_sequencer.sv =====
`default_nettype none
// Step counter and control decode; freeze on a full output register.
module brm_sequencer (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire brm_pkg::ucode_t            uc,
	input  wire brm_pkg::dp_stat_t          stat,
	output logic [brm_pkg::STEP_W-1:0]      step,
	output logic                            busy,
	output brm_pkg::dp_ctrl_t               ctrl
);
	logic [brm_pkg::STEP_W-1:0] step_q;
	logic                       busy_q;
	logic [brm_pkg::STEP_W-1:0] next_step;
	logic                       emit;
	logic                       sub;
	logic                       last;
	logic                       err;
	logic                       done;
	logic                       stall;

	always_comb begin
		emit      = 1'b0;
		sub       = 1'b0;
		last      = 1'b0;
		err       = 1'b0;
		done      = 1'b0;
		next_step = step_q;
		unique case (uc.op)
			brm_pkg::OP_CHECK: begin
				if (stat.bad) begin
					emit = 1'b1;
					last = 1'b1;
					err  = 1'b1;
					done = 1'b1;
				end else begin
					next_step = uc.fail_step;
				end
			end
			brm_pkg::OP_TERM: begin
				if (stat.ge) begin
					emit      = 1'b1;
					sub       = 1'b1;
					last      = stat.zero_after && !uc.pair;
					done      = last;
					next_step = uc.pair ? step_q + brm_pkg::STEP_W'(1) : step_q;
				end else begin
					next_step = uc.fail_step;
				end
			end
			brm_pkg::OP_SECOND: begin
				emit      = 1'b1;
				last      = stat.rest_zero;
				done      = last;
				next_step = step_q - brm_pkg::STEP_W'(1);
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	assign stall = emit && !stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q && !stall) begin
			step_q <= next_step;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		ctrl        = '0;
		ctrl.load   = start;
		ctrl.sub    = busy_q && sub && !stall;
		ctrl.emit   = busy_q && emit && !stall;
		ctrl.last   = last;
		ctrl.err    = err;
		ctrl.sym    = uc.sym;
		ctrl.weight = uc.weight;
	end

	assign step = step_q;
	assign busy = busy_q;
endmodule
`default_nettype wire

// ===== src/brm_datapath.sv =====
`default_nettype none
// Remainder register, one compare and subtract, and the output register.
module brm_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [brm_pkg::VALUE_W-1:0]  value,
	input  wire brm_pkg::dp_ctrl_t            ctrl,
	input  wire logic                         out_ready,
	output brm_pkg::dp_stat_t                 stat,
	output logic                              out_valid,
	output brm_pkg::out_payload_t             out_payload
);
	logic [brm_pkg::VALUE_W-1:0] rest_q;
	logic [brm_pkg::VALUE_W-1:0] diff;
	logic                        out_valid_q;
	brm_pkg::out_payload_t       out_q;

	assign diff = rest_q - ctrl.weight;

	always_comb begin
		stat.ge         = rest_q >= ctrl.weight;
		stat.zero_after = diff == '0;
		stat.rest_zero  = rest_q == '0;
		stat.bad        = (rest_q == '0) || (rest_q > brm_pkg::MAX_VALID);
		stat.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rest_q <= value;
		end else if (ctrl.sub) begin
			rest_q <= diff;
		end
		if (ctrl.emit) begin
			out_q.symbol      <= ctrl.sym;
			out_q.last        <= ctrl.last;
			out_q.range_error <= ctrl.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_payload = out_q;
endmodule
`default_nettype wire

// ===== src/binary_to_roman_numeral.sv =====
// The value is loaded into the remainder register, the range check runs, then the terms;
// each symbol is registered in the output register, and so is an error result of the check.
// A value holds the block until its last symbol is loaded; the single compare-and-subtract
// step walks the microprogram term by term, and a term that no longer fits takes a step
// with no symbol. A new value is taken only once the last symbol of the previous one is
// loaded; a full output register holds the program. Reset (arst_n low) clears the
// sequencer and the output valid; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module binary_to_roman_numeral (
	input  wire logic   clk,
	input  wire logic   arst_n,
	brm_stream_if.sink   item,
	brm_stream_if.source result
);
	// Control travels between the microcode table, the sequencer and the datapath.
	logic [brm_pkg::STEP_W-1:0] step;
	logic                       busy;
	logic                       start;
	brm_pkg::ucode_t            uc;
	brm_pkg::dp_ctrl_t          ctrl;
	brm_pkg::dp_stat_t          stat;
	brm_pkg::out_payload_t      res_payload;
	logic                       res_valid;

	// Take a value only while no numeral is in progress; the output register
	// lets the final symbol wait without holding up the next value.
	assign item.ready = !busy;
	assign start      = item.valid && !busy;

	brm_ucode_rom u_rom (
		.step (step),
		.uc   (uc)
	);

	brm_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.uc     (uc),
		.stat   (stat),
		.step   (step),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	brm_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (item.payload.value),
		.ctrl        (ctrl),
		.out_ready   (result.ready),
		.stat        (stat),
		.out_valid   (res_valid),
		.out_payload (res_payload)
	);

	assign result.valid   = res_valid;
	assign result.payload = res_payload;

	// An error result stands alone: marked last, no symbol.
	`ASSERT_CLKED(a_err_alone, clk, arst_n, (result.valid && result.payload.range_error) |-> (result.payload.last && result.payload.symbol == brm_pkg::SYM_NONE))
	// A normal result always carries one of the seven numerals.
	`ASSERT_CLKED(a_sym_legal, clk, arst_n, (result.valid && !result.payload.range_error) |-> (result.payload.symbol == brm_pkg::SYM_I || result.payload.symbol == brm_pkg::SYM_V || result.payload.symbol == brm_pkg::SYM_X || result.payload.symbol == brm_pkg::SYM_L || result.payload.symbol == brm_pkg::SYM_C || result.payload.symbol == brm_pkg::SYM_D || result.payload.symbol == brm_pkg::SYM_M))
	// An accepted value starts the program at the range check.
	`ASSERT_NEXT(a_start_check, clk, arst_n, start, (busy && step == '0))
	// The sequencer never emits into a full output register.
	`ASSERT_CLKED(a_no_overrun, clk, arst_n, ctrl.emit |-> stat.out_free)
endmodule
`default_nettype wire
